// ===== src/optimal_bst_cost_tables_core_assert.svh =====
// Assertion macros for the optimal BST cost table core.
`ifndef OPTIMAL_BST_COST_TABLES_CORE_ASSERT_SVH
`define OPTIMAL_BST_COST_TABLES_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define OBST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define OBST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`define OBST_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: reset behavior");
`else
`define OBST_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define OBST_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`define OBST_ASSERT_RST(lbl, clk, ante, cons)
`endif
`endif

// ===== src/obst_pkg.sv =====
// Shared types, codes and helpers for the optimal BST cost table core.
`default_nettype none
package obst_pkg;
    typedef enum logic [3:0] {
        ST_IDLE, ST_W_RD, ST_W_WR, ST_C_BND, ST_C_LD,
        ST_C_RD, ST_C_EV, ST_C_WR, ST_Q_RD, ST_Q_OUT
    } state_t;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_QUERY   = 1'b1;
    localparam logic KIND_DONE  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam int unsigned WEIGHT_W = 16;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned FIELD_W  = 5;
    localparam int unsigned CMP_W    = 9;

    typedef struct packed {
        logic store_we;
        logic store_re;
        logic wfill_wr;
        logic diag;
        logic bound_re;
        logic cand_re;
        logic cand_eval;
        logic cand_first;
        logic cell_wr;
        logic out_re;
        logic out_load;
        logic out_zero;
        logic out_kind;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

    function automatic logic [VALUE_W-1:0] sat_add(input logic [VALUE_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
        logic [VALUE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VALUE_W] ? {VALUE_W{1'b1}} : s[VALUE_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== src/obst_ctrl.sv =====
// Sequencer for loads, table fill, and queries of the optimal BST core.
`default_nettype none
module obst_ctrl #(
    parameter int unsigned MAX_KEYS = 31,
    parameter int unsigned SIDE_W   = 5
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_operation,
    input  wire logic [obst_pkg::FIELD_W-1:0] s_index,
    input  wire logic                         s_last,
    input  wire logic [obst_pkg::FIELD_W-1:0] s_range_low,
    input  wire logic [obst_pkg::FIELD_W-1:0] s_range_high,
    input  wire logic                         cfg_wr_en,
    input  wire logic [obst_pkg::FIELD_W-1:0] cfg_wr_data,
    input  wire obst_pkg::sts_t               sts,
    input  wire logic [SIDE_W-1:0]            root_lo,
    input  wire logic [SIDE_W-1:0]            root_hi,
    output obst_pkg::cmd_t                    cmd,
    output logic [SIDE_W-1:0]                 i_idx,
    output logic [SIDE_W-1:0]                 j_idx,
    output logic [SIDE_W-1:0]                 r_idx
);
    obst_pkg::state_t state_reg, state_next;
    logic [SIDE_W-1:0] i_reg, i_next, j_reg, j_next, r_reg, r_next;
    logic [SIDE_W-1:0] hi_reg, hi_next, gap_reg, gap_next, n_reg, n_next;
    logic [SIDE_W-1:0] done_reg, done_next;
    logic [obst_pkg::FIELD_W-1:0] kc_reg;
    logic first_reg, first_next, zero_reg, zero_next, kind_reg, kind_next;
    logic [SIDE_W-1:0] n_use;
    logic q_zero, idx_ok, gap_one;
    logic [obst_pkg::CMP_W-1:0] kc_ext, max_ext;

    assign kc_ext  = obst_pkg::CMP_W'(kc_reg);
    assign max_ext = obst_pkg::CMP_W'(MAX_KEYS);
    assign n_use   = (kc_reg == '0) ? SIDE_W'(1) :
                     (kc_ext > max_ext) ? SIDE_W'(MAX_KEYS) : SIDE_W'(kc_reg);
    assign idx_ok  = obst_pkg::CMP_W'(s_index) <= max_ext;
    assign q_zero  = (done_reg == '0) || (s_range_low > s_range_high) ||
                     (obst_pkg::CMP_W'(s_range_high) > obst_pkg::CMP_W'(done_reg));
    assign gap_one = gap_reg == SIDE_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= obst_pkg::ST_IDLE;
            kc_reg    <= obst_pkg::FIELD_W'(1);
            done_reg  <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_wr_en) begin
                kc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        r_reg     <= r_next;
        hi_reg    <= hi_next;
        gap_reg   <= gap_next;
        n_reg     <= n_next;
        first_reg <= first_next;
        zero_reg  <= zero_next;
        kind_reg  <= kind_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            obst_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_operation == obst_pkg::OP_QUERY) begin
                        state_next = obst_pkg::ST_Q_RD;
                    end else if (s_last) begin
                        state_next = obst_pkg::ST_W_RD;
                    end
                end
            end
            obst_pkg::ST_W_RD: state_next = obst_pkg::ST_W_WR;
            obst_pkg::ST_W_WR: begin
                state_next = (j_reg < n_reg || i_reg < n_reg) ?
                             obst_pkg::ST_W_RD : obst_pkg::ST_C_BND;
            end
            obst_pkg::ST_C_BND: state_next = obst_pkg::ST_C_LD;
            obst_pkg::ST_C_LD:  state_next = obst_pkg::ST_C_RD;
            obst_pkg::ST_C_RD:  state_next = obst_pkg::ST_C_EV;
            obst_pkg::ST_C_EV: begin
                state_next = (r_reg < hi_reg) ? obst_pkg::ST_C_RD : obst_pkg::ST_C_WR;
            end
            obst_pkg::ST_C_WR: begin
                state_next = (j_reg < n_reg || gap_reg < n_reg) ?
                             obst_pkg::ST_C_BND : obst_pkg::ST_Q_RD;
            end
            obst_pkg::ST_Q_RD: state_next = obst_pkg::ST_Q_OUT;
            obst_pkg::ST_Q_OUT: begin
                if (sts.out_free) begin
                    state_next = obst_pkg::ST_IDLE;
                end
            end
            default: state_next = obst_pkg::ST_IDLE;
        endcase
    end

    // loop counters
    always_comb begin
        i_next     = i_reg;
        j_next     = j_reg;
        r_next     = r_reg;
        hi_next    = hi_reg;
        gap_next   = gap_reg;
        n_next     = n_reg;
        first_next = first_reg;
        zero_next  = zero_reg;
        kind_next  = kind_reg;
        done_next  = done_reg;
        unique case (state_reg)
            obst_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_operation == obst_pkg::OP_QUERY) begin
                        i_next    = SIDE_W'(s_range_low);
                        j_next    = SIDE_W'(s_range_high);
                        zero_next = q_zero;
                        kind_next = obst_pkg::KIND_QUERY;
                    end else if (s_last) begin
                        n_next = n_use;
                        i_next = '0;
                        j_next = '0;
                    end
                end
            end
            obst_pkg::ST_W_WR: begin
                if (j_reg < n_reg) begin
                    j_next = j_reg + SIDE_W'(1);
                end else if (i_reg < n_reg) begin
                    i_next = i_reg + SIDE_W'(1);
                    j_next = i_reg + SIDE_W'(1);
                end else begin
                    gap_next = SIDE_W'(1);
                    i_next   = '0;
                    j_next   = SIDE_W'(1);
                end
            end
            obst_pkg::ST_C_LD: begin
                r_next     = gap_one ? j_reg : root_lo;
                hi_next    = gap_one ? j_reg : root_hi;
                first_next = 1'b1;
            end
            obst_pkg::ST_C_EV: begin
                first_next = 1'b0;
                if (r_reg < hi_reg) begin
                    r_next = r_reg + SIDE_W'(1);
                end
            end
            obst_pkg::ST_C_WR: begin
                if (j_reg < n_reg) begin
                    i_next = i_reg + SIDE_W'(1);
                    j_next = j_reg + SIDE_W'(1);
                end else if (gap_reg < n_reg) begin
                    gap_next = gap_reg + SIDE_W'(1);
                    i_next   = '0;
                    j_next   = gap_reg + SIDE_W'(1);
                end else begin
                    done_next = n_reg;
                    i_next    = '0;
                    j_next    = n_reg;
                    zero_next = 1'b0;
                    kind_next = obst_pkg::KIND_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd            = '0;
        s_ready        = state_reg == obst_pkg::ST_IDLE;
        cmd.store_we   = (state_reg == obst_pkg::ST_IDLE) && s_valid &&
                         (s_operation == obst_pkg::OP_LOAD) && idx_ok;
        cmd.store_re   = state_reg == obst_pkg::ST_W_RD;
        cmd.wfill_wr   = state_reg == obst_pkg::ST_W_WR;
        cmd.diag       = j_reg == i_reg;
        cmd.bound_re   = state_reg == obst_pkg::ST_C_BND;
        cmd.cand_re    = state_reg == obst_pkg::ST_C_RD;
        cmd.cand_eval  = state_reg == obst_pkg::ST_C_EV;
        cmd.cand_first = first_reg;
        cmd.cell_wr    = state_reg == obst_pkg::ST_C_WR;
        cmd.out_re     = state_reg == obst_pkg::ST_Q_RD;
        cmd.out_load   = (state_reg == obst_pkg::ST_Q_OUT) && sts.out_free;
        cmd.out_zero   = zero_reg;
        cmd.out_kind   = kind_reg;
    end

    assign i_idx = i_reg;
    assign j_idx = j_reg;
    assign r_idx = r_reg;
endmodule
`default_nettype wire

// ===== src/obst_dp.sv =====
// Weight stores, weight/cost/root tables, candidate compare, and result register.
`default_nettype none
module obst_dp #(
    parameter int unsigned SIDE_W = 5
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire obst_pkg::cmd_t                cmd,
    input  wire logic [SIDE_W-1:0]             i_idx,
    input  wire logic [SIDE_W-1:0]             j_idx,
    input  wire logic [SIDE_W-1:0]             r_idx,
    input  wire logic [obst_pkg::FIELD_W-1:0]  s_index,
    input  wire logic [obst_pkg::WEIGHT_W-1:0] s_success_weight,
    input  wire logic [obst_pkg::WEIGHT_W-1:0] s_fail_weight,
    output obst_pkg::sts_t                     sts,
    output logic [SIDE_W-1:0]                  root_lo,
    output logic [SIDE_W-1:0]                  root_hi,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [obst_pkg::VALUE_W-1:0]       m_cost,
    output logic [obst_pkg::VALUE_W-1:0]       m_weight,
    output logic [obst_pkg::FIELD_W-1:0]       m_root_index,
    output logic                               m_kind
);
    localparam int unsigned ADDR_W = 2 * SIDE_W;
    localparam int unsigned DEPTH  = 1 << ADDR_W;
    localparam int unsigned SDEPTH = 1 << SIDE_W;
    localparam int unsigned WW     = obst_pkg::WEIGHT_W;
    localparam int unsigned VW     = obst_pkg::VALUE_W;

    logic [2*WW-1:0] store_mem [SDEPTH];
    logic [VW-1:0]   wt_mem    [DEPTH];
    logic [VW-1:0]   cost_mem  [DEPTH];
    logic [SIDE_W-1:0] root_mem [DEPTH];

    logic [2*WW-1:0] store_q;
    logic [VW-1:0] wt_q, ca_q, cb_q;
    logic [SIDE_W-1:0] rt_a_q, rt_b_q;
    logic [VW-1:0] wprev_reg, best_reg;
    logic [SIDE_W-1:0] best_r_reg;
    logic m_valid_reg;
    logic [VW-1:0] m_cost_reg, m_weight_reg;
    logic [obst_pkg::FIELD_W-1:0] m_root_reg;
    logic m_kind_reg;

    logic [SIDE_W-1:0] sidx;
    logic [ADDR_W-1:0] cell_addr, ca_addr, cb_addr, ra_addr, rb_addr;
    logic [WW-1:0] s_q, f_q;
    logic [VW-1:0] wsum, trial, cell_cost;
    logic tbl_wr;

    assign sidx      = SIDE_W'(s_index);
    assign s_q       = store_q[2*WW-1:WW];
    assign f_q       = store_q[WW-1:0];
    assign cell_addr = {i_idx, j_idx};
    assign ca_addr   = cmd.out_re ? cell_addr : {i_idx, r_idx - SIDE_W'(1)};
    assign cb_addr   = {r_idx, j_idx};
    assign ra_addr   = cmd.out_re ? cell_addr : {i_idx, j_idx - SIDE_W'(1)};
    assign rb_addr   = {i_idx + SIDE_W'(1), j_idx};
    assign wsum      = cmd.diag ? VW'(f_q) :
                       obst_pkg::sat_add(wprev_reg, VW'(s_q) + VW'(f_q));
    assign trial     = obst_pkg::sat_add(ca_q, cb_q);
    assign cell_cost = obst_pkg::sat_add(wt_q, best_reg);
    assign tbl_wr    = (cmd.wfill_wr && cmd.diag) || cmd.cell_wr;

    always_ff @(posedge aclk) begin
        if (cmd.store_we) begin
            store_mem[sidx] <= {s_success_weight, s_fail_weight};
        end
        if (cmd.store_re) begin
            store_q <= store_mem[j_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wfill_wr) begin
            wt_mem[cell_addr] <= wsum;
        end
        if (cmd.bound_re || cmd.out_re) begin
            wt_q <= wt_mem[cell_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_wr) begin
            cost_mem[cell_addr] <= cmd.cell_wr ? cell_cost : wsum;
        end
        if (cmd.cand_re || cmd.out_re) begin
            ca_q <= cost_mem[ca_addr];
        end
        if (cmd.cand_re) begin
            cb_q <= cost_mem[cb_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_wr) begin
            root_mem[cell_addr] <= cmd.cell_wr ? best_r_reg : '0;
        end
        if (cmd.bound_re || cmd.out_re) begin
            rt_a_q <= root_mem[ra_addr];
        end
        if (cmd.bound_re) begin
            rt_b_q <= root_mem[rb_addr];
        end
    end

    // running row weight and best candidate; strict compare keeps the smallest root
    always_ff @(posedge aclk) begin
        if (cmd.wfill_wr) begin
            wprev_reg <= wsum;
        end
        if (cmd.cand_eval && (cmd.cand_first || trial < best_reg)) begin
            best_reg   <= trial;
            best_r_reg <= r_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_cost_reg   <= cmd.out_zero ? '0 : ca_q;
            m_weight_reg <= cmd.out_zero ? '0 : wt_q;
            m_root_reg   <= cmd.out_zero ? '0 : obst_pkg::FIELD_W'(rt_a_q);
            m_kind_reg   <= cmd.out_kind;
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign root_lo      = rt_a_q;
    assign root_hi      = rt_b_q;
    assign m_valid      = m_valid_reg;
    assign m_cost       = m_cost_reg;
    assign m_weight     = m_weight_reg;
    assign m_root_index = m_root_reg;
    assign m_kind       = m_kind_reg;
endmodule
`default_nettype wire

// ===== src/optimal_bst_cost_tables_core.sv =====
// Optimal BST cost table core: load weights, fill tables, answer range queries.
// Input channel s_*: operation 0 loads the key and gap weights of one index;
// with last high the load also starts the table fill. Operation 1 queries
// the cost, weight and root of gap range (range_low, range_high).
// Result channel m_*: one transfer per query (kind 1) and one per fill
// (kind 0, whole-tree cost and weight). Plain loads give no result.
// cfg_wr_en/cfg_wr_data write the key count, used by the next fill.
// Flow: a query reads the tables, then loads the result register once it is
// free. A fill walks the weight cells (read stored weights, write cell), then
// each cost cell (read root bounds, load range, read and evaluate each root
// candidate on the shared cost-table read pair, write cell), then reports.
// One item is in work at a time; s_ready is high only while idle.
// The result register holds a finished result while m_ready is low; the
// core then waits before loading the next result. Loads may still land.
// Reset (aresetn low, synchronous) returns to idle, drops any pending
// result, sets key count to 1 and marks no tables computed, so queries
// answer all zero until the first fill. Table memories are not cleared.
`default_nettype none
`include "optimal_bst_cost_tables_core_assert.svh"
module optimal_bst_cost_tables_core #(
    parameter int unsigned MAX_KEYS = 31
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_operation,
    input  wire logic [obst_pkg::FIELD_W-1:0]  s_index,
    input  wire logic [obst_pkg::WEIGHT_W-1:0] s_success_weight,
    input  wire logic [obst_pkg::WEIGHT_W-1:0] s_fail_weight,
    input  wire logic                          s_last,
    input  wire logic [obst_pkg::FIELD_W-1:0]  s_range_low,
    input  wire logic [obst_pkg::FIELD_W-1:0]  s_range_high,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [obst_pkg::VALUE_W-1:0]       m_cost,
    output logic [obst_pkg::VALUE_W-1:0]       m_weight,
    output logic [obst_pkg::FIELD_W-1:0]       m_root_index,
    output logic                               m_kind,
    input  wire logic                          cfg_wr_en,
    input  wire logic [obst_pkg::FIELD_W-1:0]  cfg_wr_data
);
    localparam int unsigned SIDE_W = $clog2(MAX_KEYS + 1);

    obst_pkg::cmd_t cmd;
    obst_pkg::sts_t sts;
    logic [SIDE_W-1:0] i_idx, j_idx, r_idx, root_lo, root_hi;

    obst_ctrl #(.MAX_KEYS(MAX_KEYS), .SIDE_W(SIDE_W)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_index(s_index), .s_last(s_last),
        .s_range_low(s_range_low), .s_range_high(s_range_high),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .sts(sts), .root_lo(root_lo), .root_hi(root_hi),
        .cmd(cmd), .i_idx(i_idx), .j_idx(j_idx), .r_idx(r_idx)
    );

    obst_dp #(.SIDE_W(SIDE_W)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .i_idx(i_idx), .j_idx(j_idx), .r_idx(r_idx),
        .s_index(s_index), .s_success_weight(s_success_weight),
        .s_fail_weight(s_fail_weight),
        .sts(sts), .root_lo(root_lo), .root_hi(root_hi),
        .m_valid(m_valid), .m_ready(m_ready), .m_cost(m_cost),
        .m_weight(m_weight), .m_root_index(m_root_index), .m_kind(m_kind)
    );

    `OBST_ASSERT_NXT(a_query_busy, aclk, aresetn, s_valid && s_ready && s_operation == obst_pkg::OP_QUERY, !s_ready)
    `OBST_ASSERT_IMP(a_done_cost_ge_weight, aclk, aresetn, m_valid && m_kind == obst_pkg::KIND_DONE, m_cost >= m_weight)
    `OBST_ASSERT_RST(a_reset_drops_result, aclk, !aresetn, !m_valid)
endmodule
`default_nettype wire
